// File: hw/rtl/cbht_pkg.sv
// Shared constants, widths and helpers for the cubic Bezier hit test block.
package cbht_pkg;

  // Curve sampling: u = k / SAMPLE_STEPS for k = 0 .. SAMPLE_STEPS.
  localparam int SAMPLE_STEPS = 100;
  localparam int CUBE         = SAMPLE_STEPS * SAMPLE_STEPS * SAMPLE_STEPS;
  localparam int CUBE_W       = $clog2(CUBE);

  // Coordinates and the scaled distance path.
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + CUBE_W;     // magnitude of a scaled offset
  localparam int E_W     = DIFF_W + 1;           // signed scaled offset
  localparam int HALF_W  = (DIFF_W + 1) / 2;     // multiplier's narrow operand
  localparam int HI_W    = DIFF_W - HALF_W;
  localparam int PROD_W  = DIFF_W + HALF_W;
  localparam int SUM_W   = 2 * DIFF_W + 1;       // dx^2 + dy^2
  localparam int K_W     = $clog2(SAMPLE_STEPS + 1);
  localparam int IDX_W   = 7;

  // Stream and register port widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int REG_ADDR_W = REG_IDX_W + 2;
  localparam int CFG_DATA_W = 32;

  // Register map.
  localparam int REG_START_X  = 0;
  localparam int REG_FIRST_X  = 2;
  localparam int REG_SECOND_X = 4;
  localparam int REG_END_X    = 6;

  // Sequencer steps inside one sample and inside the tolerance square.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_FIRST      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SAMPLE_END = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LIMIT_END  = 3'd2;

  // Scale factors of the power-basis coefficients.
  localparam logic [E_W-1:0] CUBE_E = E_W'(CUBE);
  localparam logic [E_W-1:0] C3N2_E = E_W'(3 * SAMPLE_STEPS * SAMPLE_STEPS);
  localparam logic [E_W-1:0] C3N_E  = E_W'(3 * SAMPLE_STEPS);

  // Sign-extend a coordinate to the scaled offset width.
  function automatic logic [E_W-1:0] sext_e(input logic [COORD_W-1:0] v);
    return {{(E_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage

// File: hw/rtl/cubic_bezier_hit_test.sv
// Cubic Bezier hit test: forward-difference sampler with one shared squaring multiplier.
// Each of the SAMPLE_STEPS+1 samples is squared per axis on the one shared multiplier
// (two partial products per squared axis plus the compare); setup comes before the
// samples and the tolerance square after them. One request in flight: in_tready is high
// only when idle, so a new request is taken only after the last result has been loaded
// into the result register, which waits while a held result is not yet taken.
// Reset (synchronous, active low) clears the control points, the sequencer and out_tvalid.
module cubic_bezier_hit_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] query_x, [31:16] query_y, [47:32] tolerance
  input  logic [cbht_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] hit, [7:1] nearest_sample
  output logic [cbht_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cbht_pkg::REG_ADDR_W-1:0]    cfg_paddr,
  input  logic [cbht_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [cbht_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import cbht_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_RUN   = 5'b00100,
    S_LIMIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Control point registers.
  logic [COORD_W-1:0]   ctl_r [NUM_REGS];
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]   cfg_rd_val;

  // Sequencer.
  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [K_W-1:0]    k_r, k_nxt;

  // Forward-difference state per axis (0 is x, 1 is y), modulo 2^E_W.
  logic [E_W-1:0] err_r [2];
  logic [E_W-1:0] err_nxt [2];
  logic [E_W-1:0] d1_r [2];
  logic [E_W-1:0] d1_nxt [2];
  logic [E_W-1:0] d2_r [2];
  logic [E_W-1:0] d2_nxt [2];
  logic [E_W-1:0] d3_r [2];
  logic [E_W-1:0] d3_nxt [2];
  logic [E_W-1:0] neg_err [2];
  logic [DIFF_W-1:0] mag [2];

  // Setup terms from the control points and the query.
  logic [E_W-1:0] p0 [2];
  logic [E_W-1:0] p1 [2];
  logic [E_W-1:0] p2 [2];
  logic [E_W-1:0] p3 [2];
  logic [E_W-1:0] qe [2];
  logic [E_W-1:0] e0 [2];
  logic [E_W-1:0] c1 [2];
  logic [E_W-1:0] c2 [2];
  logic [E_W-1:0] c3 [2];

  // Shared multiplier and accumulator.
  logic [DIFF_W-1:0] tol_n3_r, tol_n3_nxt;
  logic [DIFF_W-1:0] mul_src;
  logic [HALF_W-1:0] mul_part;
  logic [PROD_W-1:0] prod_r;
  logic              prod_hi_r;
  logic [SUM_W-1:0]  add_term;
  logic [SUM_W-1:0]  acc_sum;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [SUM_W-1:0]  best_r, best_nxt;
  logic [K_W-1:0]    best_k_r, best_k_nxt;
  logic              closer;
  logic              hit_r, hit_nxt;

  // Result register.
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                  out_load;

  // Configuration port: writes complete in the access phase, reads are combinational.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[REG_ADDR_W-1:2];
  assign cfg_rd_val = ctl_r[cfg_idx];
  assign cfg_prdata = {{(CFG_DATA_W - COORD_W){cfg_rd_val[COORD_W-1]}}, cfg_rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (cfg_write) begin
      ctl_r[cfg_idx] <= cfg_pwdata[COORD_W-1:0];
    end
  end

  // Power-basis coefficients of the curve minus the query, per axis.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      p0[a] = sext_e(ctl_r[REG_START_X + a]);
      p1[a] = sext_e(ctl_r[REG_FIRST_X + a]);
      p2[a] = sext_e(ctl_r[REG_SECOND_X + a]);
      p3[a] = sext_e(ctl_r[REG_END_X + a]);
      qe[a] = sext_e((a == 0) ? in_tdata[15:0] : in_tdata[31:16]);
      e0[a] = (p0[a] - qe[a]) * CUBE_E;
      c1[a] = (p1[a] - p0[a]) * C3N2_E;
      c2[a] = (p0[a] - (p1[a] << 1) + p2[a]) * C3N_E;
      c3[a] = (p3[a] - p0[a]) + ((p1[a] - p2[a]) << 1) + (p1[a] - p2[a]);
      neg_err[a] = -err_r[a];
      mag[a] = err_r[a][E_W-1] ? neg_err[a][DIFF_W-1:0] : err_r[a][DIFF_W-1:0];
    end
  end

  // Shared multiplier: operand times its low or high half; squares build from the two partial products.
  assign mul_src  = (state_r == S_LIMIT) ? tol_n3_r : (step_r[1] ? mag[1] : mag[0]);
  assign mul_part = step_r[0] ? HALF_W'(mul_src[DIFF_W-1:HALF_W]) : mul_src[HALF_W-1:0];

  always_ff @(posedge clk) begin
    prod_r    <= PROD_W'(mul_src) * PROD_W'(mul_part);
    prod_hi_r <= step_r[0];
  end

  assign add_term = prod_hi_r ? (SUM_W'(prod_r) << HALF_W) : SUM_W'(prod_r);
  assign acc_sum  = acc_r + add_term;
  assign closer   = acc_sum < best_r;

  // Sequencer: setup, one five-step pass per sample, then the tolerance square.
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    k_nxt      = k_r;
    tol_n3_nxt = tol_n3_r;
    acc_nxt    = acc_r;
    best_nxt   = best_r;
    best_k_nxt = best_k_r;
    hit_nxt    = hit_r;
    out_load   = 1'b0;
    for (int a = 0; a < 2; a++) begin
      err_nxt[a] = err_r[a];
      d1_nxt[a]  = d1_r[a];
      d2_nxt[a]  = d2_r[a];
      d3_nxt[a]  = d3_r[a];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt  = S_INIT;
          tol_n3_nxt = DIFF_W'(in_tdata[47:32]) * DIFF_W'(CUBE);
          for (int a = 0; a < 2; a++) begin
            err_nxt[a] = e0[a];
            d1_nxt[a]  = c1[a];
            d2_nxt[a]  = c2[a];
            d3_nxt[a]  = c3[a];
          end
        end
      end
      S_INIT: begin
        // Turn coefficients into first, second and third forward differences.
        for (int a = 0; a < 2; a++) begin
          d1_nxt[a] = d1_r[a] + d2_r[a] + d3_r[a];
          d2_nxt[a] = (d2_r[a] << 1) + (d3_r[a] << 2) + (d3_r[a] << 1);
          d3_nxt[a] = (d3_r[a] << 2) + (d3_r[a] << 1);
        end
        step_nxt  = STEP_FIRST;
        k_nxt     = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        acc_nxt = (step_r == STEP_FIRST) ? '0 : acc_sum;
        if (step_r == STEP_SAMPLE_END) begin
          // Keep the first nearest sample; ties stay with the lower index.
          if (k_r == '0 || closer) begin
            best_nxt   = acc_sum;
            best_k_nxt = k_r;
          end
          for (int a = 0; a < 2; a++) begin
            err_nxt[a] = err_r[a] + d1_r[a];
            d1_nxt[a]  = d1_r[a] + d2_r[a];
            d2_nxt[a]  = d2_r[a] + d3_r[a];
          end
          step_nxt = STEP_FIRST;
          if (k_r == K_W'(SAMPLE_STEPS)) begin
            state_nxt = S_LIMIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LIMIT: begin
        acc_nxt = (step_r == STEP_FIRST) ? '0 : acc_sum;
        if (step_r == STEP_LIMIT_END) begin
          // Hit unless the squared tolerance is below the best squared distance.
          hit_nxt   = !closer;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register holds until the downstream side takes it.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {IDX_W'(best_k_r), hit_r};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= STEP_FIRST;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tol_n3_r    <= tol_n3_nxt;
    acc_r       <= acc_nxt;
    best_r      <= best_nxt;
    best_k_r    <= best_k_nxt;
    hit_r       <= hit_nxt;
    out_tdata_r <= out_tdata_nxt;
    for (int a = 0; a < 2; a++) begin
      err_r[a] <= err_nxt[a];
      d1_r[a]  <= d1_nxt[a];
      d2_r[a]  <= d2_nxt[a];
      d3_r[a]  <= d3_nxt[a];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: tb/sv/cbht_checker.sv
// Scoreboard for the cubic Bezier hit test: tracks control points, predicts results, compares.
module cbht_checker
  import cbht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  // [15:0] query_x, [31:16] query_y, [47:32] tolerance
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  // [0] hit, [7:1] nearest_sample
  input  logic [OUT_DATA_W-1:0]   out_tdata,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [REG_ADDR_W-1:0]   cfg_paddr,
  input  logic [CFG_DATA_W-1:0]   cfg_pwdata,
  input  logic [CFG_DATA_W-1:0]   cfg_prdata,
  input  logic                    cfg_pready,
  output int                      mismatch_count,
  output int                      pending_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             nearest_hit;
    logic [IDX_W-1:0] nearest_idx;
  } hit_result_t;

  // Shadow copy of the control point registers.
  logic signed [COORD_W-1:0] ctrl_pts [NUM_REGS];
  hit_result_t               awaited_hits [$];
  int                        errors = 0;

  // Curve coordinate of sample k, scaled by SAMPLE_STEPS cubed (axis 0 is x, 1 is y).
  function automatic longint scaled_sample(input longint k, input int axis);
    longint j;
    j = longint'(SAMPLE_STEPS) - k;
    return j * j * j * longint'(ctrl_pts[REG_START_X + axis])
         + 3 * k * j * j * longint'(ctrl_pts[REG_FIRST_X + axis])
         + 3 * k * k * j * longint'(ctrl_pts[REG_SECOND_X + axis])
         + k * k * k * longint'(ctrl_pts[REG_END_X + axis]);
  endfunction

  // Walk every sample, keep the first nearest one, then test it against the tolerance.
  function automatic hit_result_t nearest_sample_of(input logic signed [COORD_W-1:0] qx,
                                                    input logic signed [COORD_W-1:0] qy,
                                                    input logic [COORD_W-1:0]        tol);
    longint       cube, px, py, dx, dy, k, best_k;
    logic [127:0] sq_dist, best, lim, tol_scaled;
    hit_result_t  res;
    cube   = longint'(SAMPLE_STEPS) * SAMPLE_STEPS * SAMPLE_STEPS;
    px     = longint'(qx) * cube;
    py     = longint'(qy) * cube;
    best   = '0;
    best_k = 0;
    for (k = 0; k <= SAMPLE_STEPS; k++) begin
      dx = px - scaled_sample(k, 0);
      dy = py - scaled_sample(k, 1);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq_dist = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
      if (k == 0 || sq_dist < best) begin
        best   = sq_dist;
        best_k = k;
      end
    end
    tol_scaled      = 128'(tol) * 128'(cube);
    lim             = tol_scaled * tol_scaled;
    res.nearest_hit = !(lim < best);
    res.nearest_idx = best_k[IDX_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hit_result_t exp_res;
    int          idx;
    idx = int'(cfg_paddr[REG_ADDR_W-1:2]);
    if (!rst_n) begin
      foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
      awaited_hits.delete();
    end else begin
      // Register writes and read-back.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (idx < NUM_REGS) ctrl_pts[idx] = cfg_pwdata[COORD_W-1:0];
        end else if (idx < NUM_REGS && cfg_prdata[COORD_W-1:0] != ctrl_pts[idx]) begin
          $error("register %0d: expected %0d, actual %0d", idx, ctrl_pts[idx],
                 $signed(cfg_prdata[COORD_W-1:0]));
          errors++;
        end
      end

      // Each accepted request yields exactly one result.
      if (in_tvalid && in_tready) begin
        awaited_hits.push_back(nearest_sample_of(in_tdata[15:0], in_tdata[31:16],
                                                 in_tdata[47:32]));
      end

      if (out_tvalid && out_tready) begin
        if (awaited_hits.size() == 0) begin
          $error("result with no request waiting: hit %0d nearest_sample %0d",
                 out_tdata[0], out_tdata[7:1]);
          errors++;
        end else begin
          // Oldest prediction first.
          exp_res = awaited_hits[0];
          awaited_hits.delete(0);
          if (out_tdata[0] != exp_res.nearest_hit) begin
            $error("hit: expected %0d, actual %0d", exp_res.nearest_hit, out_tdata[0]);
            errors++;
          end
          if (out_tdata[7:1] != exp_res.nearest_idx) begin
            $error("nearest_sample: expected %0d, actual %0d", exp_res.nearest_idx,
                   out_tdata[7:1]);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_hits   <= awaited_hits.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top testbench for the cubic Bezier hit test: clock, reset, stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbht_pkg::*;

  localparam int     RANDOM_PHASES  = 12;
  localparam int     PHASE_REQUESTS = 100;
  localparam int     LONG_HOLD      = 1500;
  localparam int     DRAIN_TAIL     = 5 * SAMPLE_STEPS + 20;
  localparam longint CYCLE_LIMIT    = 4_000_000;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic [COORD_W-1:0]        TOL_MAX   = 16'hFFFF;

  typedef enum int {CURVE_WIDE, CURVE_TIGHT, CURVE_CORNERS, CURVE_POINT, CURVE_LOOP}
    curve_shape_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    mismatch_count;
  int                    pending_hits;

  // Stimulus-side state: hold-off requests to the receiver and the current curve.
  int                        hold_requests = 0;
  int                        holds_done    = 0;
  bit                        steady        = 1'b0;
  logic signed [COORD_W-1:0] curve_pts [NUM_REGS];

  cubic_bezier_hit_test u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cbht_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pending_hits   (pending_hits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit, well above the slowest correct run.
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Idle length: mostly short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
    if (v > int'(COORD_MAX)) return COORD_MAX;
    if (v < int'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Result side: random back-pressure, plus a long hold-off when asked.
  always begin
    if (holds_done != hold_requests) begin
      out_tready <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk);
      holds_done++;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
      @(posedge clk);
    end else begin
      out_tready <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  end

  // One register transfer: setup phase, access phase held until cfg_pready, then idle.
  task automatic cfg_access(input bit wr, input int idx, input logic [COORD_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_ADDR_W'(idx * 4);
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write every control point, then read all of them back.
  task automatic program_curve();
    for (int i = 0; i < NUM_REGS; i++) cfg_access(1'b1, i, curve_pts[i]);
    for (int i = 0; i < NUM_REGS; i++) cfg_access(1'b0, i, '0);
  endtask

  // Offer one request and hold it until accepted; then maybe leave a gap.
  task automatic send_query(input logic signed [COORD_W-1:0] qx,
                            input logic signed [COORD_W-1:0] qy,
                            input logic [COORD_W-1:0]        tol);
    int gap;
    in_tdata  <= {tol, qy, qx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = (steady || $urandom_range(0, 9) < 4) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every request has produced its result.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits != 0) @(posedge clk);
  endtask

  task automatic pick_curve(input curve_shape_t shape);
    logic signed [COORD_W-1:0] cx, cy;
    cx = COORD_W'($urandom);
    cy = COORD_W'($urandom);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (shape)
        CURVE_WIDE:    curve_pts[i] = COORD_W'($urandom);
        CURVE_TIGHT:   curve_pts[i] = clamp_coord((i % 2 ? int'(cy) : int'(cx))
                                                  + int'($urandom_range(0, 1000)) - 500);
        CURVE_CORNERS: curve_pts[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        CURVE_POINT:   curve_pts[i] = (i % 2) ? cy : cx;
        default:       curve_pts[i] = COORD_W'($urandom);
      endcase
    end
    // A closed loop: end on the start, both anchors together, so samples pair up as ties.
    if (shape == CURVE_LOOP) begin
      curve_pts[REG_END_X]      = curve_pts[REG_START_X];
      curve_pts[REG_END_X + 1]  = curve_pts[REG_START_X + 1];
      curve_pts[REG_SECOND_X]   = curve_pts[REG_FIRST_X];
      curve_pts[REG_SECOND_X+1] = curve_pts[REG_FIRST_X + 1];
    end
  endtask

  // Mostly queries near a control point with small tolerances, the rest anywhere.
  task automatic random_query();
    logic signed [COORD_W-1:0] qx, qy;
    logic [COORD_W-1:0]        tol;
    int                        c, spread;
    if ($urandom_range(0, 9) < 3) begin
      qx = COORD_W'($urandom);
      qy = COORD_W'($urandom);
    end else begin
      c = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 3;
        2:       spread = 60;
        default: spread = 3000;
      endcase
      qx = clamp_coord(int'(curve_pts[2 * c]) + int'($urandom_range(0, 2 * spread)) - spread);
      qy = clamp_coord(int'(curve_pts[2 * c + 1]) + int'($urandom_range(0, 2 * spread))
                       - spread);
    end
    case ($urandom_range(0, 3))
      0:       tol = '0;
      1:       tol = COORD_W'($urandom_range(0, 7));
      2:       tol = COORD_W'($urandom_range(0, 1023));
      default: tol = COORD_W'($urandom);
    endcase
    send_query(qx, qy, tol);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers must read back as zero after reset.
    foreach (curve_pts[i]) curve_pts[i] = '0;
    for (int i = 0; i < NUM_REGS; i++) cfg_access(1'b0, i, '0);

    // Degenerate zero curve: every sample ties, so the first one wins.
    send_query(16'sd0, 16'sd0, 16'd0);
    send_query(COORD_MAX, COORD_MIN, TOL_MAX);
    send_query(COORD_MIN, COORD_MAX, 16'd0);
    send_query(COORD_MIN, COORD_MIN, TOL_MAX);
    drain();

    // Curve through the corners of the coordinate range; the end point is an exact hit.
    curve_pts = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX};
    program_curve();
    send_query(COORD_MAX, COORD_MAX, 16'd0);
    send_query(COORD_MIN, COORD_MIN, 16'd0);
    send_query(COORD_MAX, COORD_MIN, 16'd0);
    send_query(16'sd0, 16'sd0, TOL_MAX);
    send_query(16'sd0, 16'sd0, 16'd0);
    send_query(COORD_MIN, COORD_MAX, 16'd1);
    drain();

    // Out-and-back loop: first and last samples tie; distance exactly at the tolerance.
    curve_pts = '{16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0};
    program_curve();
    send_query(-16'sd5000, 16'sd0, 16'd5000);
    send_query(-16'sd5000, 16'sd0, 16'd4999);
    send_query(16'sd5000, 16'sd0, 16'd0);
    send_query(16'sd0, 16'sd0, 16'd0);
    drain();

    // Whole curve collapsed onto one point.
    curve_pts = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1};
    program_curve();
    send_query(-16'sd1, -16'sd1, 16'd0);
    send_query(COORD_MAX, COORD_MAX, TOL_MAX);
    send_query(COORD_MIN, COORD_MIN, 16'd0);
    drain();

    // Random phases over all curve shapes, some with no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p % 4 == 1);
      pick_curve(curve_shape_t'(p % 5));
      program_curve();
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 2 && n == 20) hold_requests++;
        random_query();
      end
      drain();
    end
    steady = 1'b0;

    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_hits != 0) $error("%0d results never arrived", pending_hits);
    if (mismatch_count == 0 && pending_hits == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
